// ----- rtl/assert_macros.svh -----
// Assertion macros used by the deframer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define MLMD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Checks that a condition implies a consequence in the following cycle.
`define MLMD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

// ----- rtl/mlmd_pkg.sv -----
// Types and constants for the magic and length message deframer.
package mlmd_pkg;

  localparam int unsigned HDR_BYTES = 12;
  localparam logic [31:0] LIMIT_RST = 32'd4096;

  localparam int unsigned ADDR_W = 4;

  typedef enum logic [1:0] {
    EV_BODY    = 2'd0,
    EV_EMPTY   = 2'd1,
    EV_CORRUPT = 2'd2
  } ev_kind_t;

  typedef enum logic [1:0] {
    REG_MAGIC = 2'd0,
    REG_LINK  = 2'd1,
    REG_LIMIT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] magic;
    logic        link;
    logic [32:0] thresh;
  } cfg_t;

  typedef struct packed {
    ev_kind_t    kind;
    logic [7:0]  body_byte;
    logic [31:0] msg_type;
    logic        last;
  } res_t;

endpackage

// ----- rtl/magic_length_message_deframer.sv -----
// Top level of the magic and length message deframer.
// The block takes one stream byte per cycle, unless out_stall holds it, and
// emits at most one event per byte: a body byte with its message type, an
// empty-message event or a corrupt-header event. A byte is held in an input
// register, parsed combinationally and its event lands in a result register,
// from which it is presented on the result port. Back pressure on out_stall
// holds the result register and, while the input register also holds a byte,
// stalls the input in the same cycle. Register writes take effect at the next
// completed header and are meant to be made while the stream is idle.
`include "assert_macros.svh"

module magic_length_message_deframer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_event_kind,
  output logic [7:0]                 out_body_byte,
  output logic [31:0]                out_message_type,
  output logic                       out_last_byte,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mlmd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import mlmd_pkg::*;

  cfg_t       cfg;
  res_t       res;
  res_t       out_r;
  logic       res_vld;
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       out_vld_r;
  logic       adv;
  logic       fire;

  mlmd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign adv      = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && adv;
  assign in_stall = in_vld_r && !adv;

  mlmd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .byte_in (in_byte_r),
    .cfg     (cfg),
    .res_vld (res_vld),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= fire && res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && fire && res_vld) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_event_kind   = out_r.kind;
  assign out_body_byte    = out_r.body_byte;
  assign out_message_type = out_r.msg_type;
  assign out_last_byte    = out_r.last;

  `MLMD_ASSERT_IMP(a_stall_src, in_stall, out_vld_r && out_stall)
  `MLMD_ASSERT_NXT(a_stall_hold, in_stall, out_vld_r)
  `MLMD_ASSERT_IMP(a_corrupt_clean, out_vld_r && (out_r.kind == EV_CORRUPT),
                   (out_r.msg_type == 32'd0) && !out_r.last)
  `MLMD_ASSERT_IMP(a_last_body, out_vld_r && out_r.last, out_r.kind == EV_BODY)

endmodule

// ----- rtl/mlmd_cfg_regs.sv -----
// Configuration register file with an APB-style access port.
module mlmd_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mlmd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output mlmd_pkg::cfg_t             cfg
);
  import mlmd_pkg::*;

  logic [31:0] magic_r;
  logic        link_r;
  logic [31:0] limit_r;
  logic [32:0] thresh_r;
  logic        wr_en;
  reg_idx_t    idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r  <= '0;
      link_r   <= 1'b0;
      limit_r  <= LIMIT_RST;
      thresh_r <= {1'b0, LIMIT_RST} + 33'(HDR_BYTES);
    end else if (wr_en) begin
      unique case (idx)
        REG_MAGIC: magic_r <= pwdata;
        REG_LINK:  link_r  <= pwdata[0];
        REG_LIMIT: begin
          limit_r  <= pwdata;
          thresh_r <= {1'b0, pwdata} + 33'(HDR_BYTES);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MAGIC: prdata = magic_r;
      REG_LINK:  prdata = {31'd0, link_r};
      REG_LIMIT: prdata = limit_r;
      default:   prdata = '0;
    endcase
  end

  // The threshold is the limit plus the header size, so that the body check
  // compares the total length directly.
  assign cfg.magic  = magic_r;
  assign cfg.link   = link_r;
  assign cfg.thresh = thresh_r;

endmodule

// ----- rtl/mlmd_parser.sv -----
// Header and body parser that turns one byte into at most one event.
module mlmd_parser (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  logic [7:0]     byte_in,
  input  mlmd_pkg::cfg_t cfg,
  output logic           res_vld,
  output mlmd_pkg::res_t res
);
  import mlmd_pkg::*;

  logic        in_header_r, in_header_nxt;
  logic [31:0] bytes_left_r, bytes_left_nxt;
  logic [95:0] hdr_r, hdr_nxt;
  logic [95:0] shifted;
  logic [31:0] len;
  logic        len_short;
  logic        too_big;
  logic        last;

  assign shifted   = {hdr_r[87:0], byte_in};
  assign len       = shifted[63:32];
  assign len_short = (len <= 32'(HDR_BYTES));
  assign too_big   = !cfg.link && ({1'b0, len} >= cfg.thresh);
  assign last      = (bytes_left_r <= 32'd1);

  always_comb begin
    in_header_nxt  = in_header_r;
    bytes_left_nxt = bytes_left_r;
    hdr_nxt        = hdr_r;
    res_vld        = 1'b0;
    res.kind       = EV_BODY;
    res.body_byte  = 8'd0;
    res.msg_type   = 32'd0;
    res.last       = 1'b0;
    if (in_header_r) begin
      hdr_nxt = shifted;
      if (bytes_left_r > 32'd1) begin
        bytes_left_nxt = bytes_left_r - 32'd1;
      end else if (shifted[95:64] != cfg.magic) begin
        res_vld        = 1'b1;
        res.kind       = EV_CORRUPT;
        bytes_left_nxt = 32'(HDR_BYTES);
        hdr_nxt        = '0;
      end else if (len_short || too_big) begin
        res_vld        = 1'b1;
        res.kind       = EV_EMPTY;
        res.msg_type   = shifted[31:0];
        bytes_left_nxt = 32'(HDR_BYTES);
        hdr_nxt        = '0;
      end else begin
        in_header_nxt  = 1'b0;
        bytes_left_nxt = len - 32'(HDR_BYTES);
      end
    end else begin
      res_vld       = 1'b1;
      res.kind      = EV_BODY;
      res.body_byte = byte_in;
      res.msg_type  = hdr_r[31:0];
      res.last      = last;
      if (last) begin
        in_header_nxt  = 1'b1;
        bytes_left_nxt = 32'(HDR_BYTES);
        hdr_nxt        = '0;
      end else begin
        bytes_left_nxt = bytes_left_r - 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_header_r  <= 1'b1;
      bytes_left_r <= 32'(HDR_BYTES);
      hdr_r        <= '0;
    end else if (fire) begin
      in_header_r  <= in_header_nxt;
      bytes_left_r <= bytes_left_nxt;
      hdr_r        <= hdr_nxt;
    end
  end

endmodule

// ----- tb/sv/magic_length_message_deframer_tb.sv -----
// Self-checking testbench for the magic and length message deframer.
`timescale 1ns / 1ps

class deframe_events;
  logic [31:0] magic_cfg = '0;
  logic        link_cfg  = 1'b0;
  logic [31:0] limit_cfg = mlmd_pkg::LIMIT_RST;

  logic        hdr_phase = 1'b1;
  logic [31:0] remaining = mlmd_pkg::HDR_BYTES;
  logic [31:0] w_magic   = '0;
  logic [31:0] w_len     = '0;
  logic [31:0] w_type    = '0;

  mlmd_pkg::res_t pending_events[$];
  int unsigned    accepted   = 0;
  int unsigned    bad_events = 0;

  function void set_reg(mlmd_pkg::reg_idx_t idx, logic [31:0] value);
    case (idx)
      mlmd_pkg::REG_MAGIC: magic_cfg = value;
      mlmd_pkg::REG_LINK:  link_cfg  = value[0];
      mlmd_pkg::REG_LIMIT: limit_cfg = value;
      default: ;
    endcase
  endfunction

  function void restart_header();
    hdr_phase = 1'b1;
    remaining = mlmd_pkg::HDR_BYTES;
    w_magic   = '0;
    w_len     = '0;
    w_type    = '0;
  endfunction

  function void push_event(mlmd_pkg::ev_kind_t kind, logic [7:0] data,
                           logic [31:0] mtype, logic last);
    mlmd_pkg::res_t ev;
    ev.kind      = kind;
    ev.body_byte = data;
    ev.msg_type  = mtype;
    ev.last      = last;
    pending_events.push_back(ev);
  endfunction

  // Advances the parser by one accepted stream byte.
  function void take_byte(logic [7:0] value);
    logic [31:0] body;
    logic        last;
    accepted++;
    if (hdr_phase) begin
      w_magic = {w_magic[23:0], w_len[31:24]};
      w_len   = {w_len[23:0], w_type[31:24]};
      w_type  = {w_type[23:0], value};
      if (remaining > 1) begin
        remaining--;
        return;
      end
      body = (w_len < mlmd_pkg::HDR_BYTES) ? 32'd0 : w_len - mlmd_pkg::HDR_BYTES;
      if (!link_cfg && body >= limit_cfg) begin
        body = '0;
      end
      if (w_magic != magic_cfg) begin
        push_event(mlmd_pkg::EV_CORRUPT, 8'd0, 32'd0, 1'b0);
        restart_header();
      end else if (body == 0) begin
        push_event(mlmd_pkg::EV_EMPTY, 8'd0, w_type, 1'b0);
        restart_header();
      end else begin
        hdr_phase = 1'b0;
        remaining = body;
      end
    end else begin
      last = (remaining <= 1);
      push_event(mlmd_pkg::EV_BODY, value, w_type, last);
      if (last) begin
        restart_header();
      end else begin
        remaining--;
      end
    end
  endfunction

  function void flag(string what, mlmd_pkg::res_t want, mlmd_pkg::res_t got);
    bad_events++;
    if (bad_events <= 10) begin
      $display("%s: expected kind=%0d byte=%02h type=%08h last=%0b, actual kind=%0d byte=%02h type=%08h last=%0b",
               what, want.kind, want.body_byte, want.msg_type, want.last,
               got.kind, got.body_byte, got.msg_type, got.last);
    end
  endfunction

  function void match_event(logic [1:0] kind, logic [7:0] data, logic [31:0] mtype,
                            logic last);
    mlmd_pkg::res_t want;
    mlmd_pkg::res_t got;
    got.kind      = mlmd_pkg::ev_kind_t'(kind);
    got.body_byte = data;
    got.msg_type  = mtype;
    got.last      = last;
    if (pending_events.size() == 0) begin
      want = '0;
      flag("Unexpected event", want, got);
      return;
    end
    want = pending_events.pop_front();
    if (kind !== want.kind || data !== want.body_byte || mtype !== want.msg_type ||
        last !== want.last) begin
      flag("Event mismatch", want, got);
    end
  endfunction
endclass

module magic_length_message_deframer_tb;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_BYTES   = 75;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_event_kind;
  logic [7:0]  out_body_byte;
  logic [31:0] out_message_type;
  logic        out_last_byte;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [mlmd_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_count = 0;

  deframe_events tracker = new();

  magic_length_message_deframer uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_kind   (out_event_kind),
    .out_body_byte    (out_body_byte),
    .out_message_type (out_message_type),
    .out_last_byte    (out_last_byte),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.match_event(out_event_kind, out_body_byte, out_message_type, out_last_byte);
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_byte(input logic [7:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_byte  <= 8'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_byte(value);
  endtask

  task automatic write_reg(input mlmd_pkg::reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Lengths stay small unless the body is cut to empty, so runs stay short.
  function automatic logic [31:0] pick_length();
    logic [63:0] wide;
    logic [31:0] len;
    logic [31:0] body;
    int unsigned sel;
    sel = $urandom_range(99);
    len = mlmd_pkg::HDR_BYTES + $urandom_range(1, 12);
    if (sel < 12) begin
      len = $urandom_range(0, 11);
    end else if (sel < 20) begin
      len = mlmd_pkg::HDR_BYTES;
    end else if (sel < 35) begin
      if (!tracker.link_cfg && tracker.limit_cfg <= 32'hFFFF_FF00) begin
        wide = 64'(tracker.limit_cfg) + mlmd_pkg::HDR_BYTES + $urandom_range(0, 200);
        len  = wide[31:0];
      end
    end else if (sel < 45) begin
      if (tracker.limit_cfg >= 1 && tracker.limit_cfg <= 40) begin
        len = tracker.limit_cfg + mlmd_pkg::HDR_BYTES - 1;
      end
    end else if (sel < 60) begin
      len  = $urandom;
      body = (len < mlmd_pkg::HDR_BYTES) ? 32'd0 : len - mlmd_pkg::HDR_BYTES;
      if ((tracker.link_cfg || body < tracker.limit_cfg) && body > 40) begin
        len = mlmd_pkg::HDR_BYTES + $urandom_range(1, 12);
      end
    end
    return len;
  endfunction

  task automatic send_header(input logic [31:0] magic, input logic [31:0] len,
                             input logic [31:0] mtype);
    logic [95:0] hdr;
    hdr = {magic, len, mtype};
    for (int i = 0; i < 12; i++) begin
      send_byte(hdr[95 - 8 * i -: 8]);
    end
  endtask

  task automatic send_message(input logic [31:0] magic);
    send_header(magic, pick_length(), $urandom);
    while (!tracker.hdr_phase) send_byte(8'($urandom));
  endtask

  // The last magic byte is forced to mismatch so a broken header never opens a long body.
  task automatic resync();
    while (!(tracker.hdr_phase && tracker.remaining == mlmd_pkg::HDR_BYTES)) begin
      if (tracker.hdr_phase && tracker.remaining == 9) begin
        send_byte(~tracker.magic_cfg[7:0]);
      end else begin
        send_byte(8'($urandom));
      end
    end
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned start;
    int unsigned sel;
    logic [31:0] flip;
    start = tracker.accepted;
    while (tracker.accepted - start < count) begin
      sel = $urandom_range(99);
      if (sel < 12) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        resync();
      end else if (sel < 25) begin
        flip = $urandom;
        if (flip == 0) begin
          flip = 32'd1;
        end
        send_message(tracker.magic_cfg ^ flip);
      end else begin
        send_message(tracker.magic_cfg);
      end
    end
  endtask

  task automatic apply_config(input logic [31:0] magic, input logic link,
                              input logic [31:0] limit);
    write_reg(mlmd_pkg::REG_MAGIC, magic);
    write_reg(mlmd_pkg::REG_LINK, {31'd0, link});
    write_reg(mlmd_pkg::REG_LIMIT, limit);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_header(32'h0000_0000, 32'd14, 32'hFFFF_FFFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_header(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        1: apply_config(32'hFFFF_FFFF, 1'b0, 32'd0);
        2: apply_config(32'hA5C3_0F1E, 1'b1, 32'd0);
        3: apply_config($urandom, 1'b0, 32'd16);
        4: apply_config($urandom, 1'b1, 32'hFFFF_FFFF);
        5: apply_config(32'h0000_0000, 1'b0, 32'hFFFF_FFFF);
        6: apply_config($urandom, 1'b0, 32'd1);
        7: apply_config(32'hFFFF_FFFF, 1'b1, mlmd_pkg::LIMIT_RST);
        default: ;
      endcase
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 64;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 64;
        end
        default: begin
          send_idle_pct = 21;
          stall_pct = 21;
        end
      endcase
      run_random(PHASE_BYTES);
      drain();
    end

    if (tracker.bad_events == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/mlmd_pkg.sv
rtl/mlmd_cfg_regs.sv
rtl/mlmd_parser.sv
rtl/magic_length_message_deframer.sv
tb/sv/magic_length_message_deframer_tb.sv
